// ===== hw/rtl/postfix_expression_evaluator_unit_defines.svh =====
`ifndef POSTFIX_EXPRESSION_EVALUATOR_UNIT_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_UNIT_DEFINES_SVH

// Concurrent check sampled on aclk, switched off while reset is held.
`define PFX_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Concurrent check sampled on aclk, active during reset too.
`define PFX_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hw/rtl/pfx_pkg.sv =====
`timescale 1ns / 1ps

package pfx_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int DATA_W          = 32;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_ADD  = 8'h2B;
    localparam logic [7:0] CHAR_SUB  = 8'h2D;
    localparam logic [7:0] CHAR_MUL  = 8'h2A;
    localparam logic [7:0] CHAR_DIV  = 8'h2F;

    // Value returned by a pop of an empty stack
    localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } pfx_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     underflow_seen;
        logic                     overflow_seen;
        logic                     div_zero_seen;
    } pfx_out_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_DIGIT,
        CMD_ADD,
        CMD_SUB,
        CMD_MUL,
        CMD_DIV
    } pfx_kind_t;

    typedef struct packed {
        pfx_kind_t  kind;
        logic [3:0] digit;
        logic       last;
    } pfx_cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_DIV,
        BK_FIN
    } pfx_back_state_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } pfx_div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } pfx_div_rsp_t;

endpackage

// ===== hw/rtl/postfix_expression_evaluator_unit.sv =====
// Postfix evaluator: characters enter one per transfer and are classified in
// the front stage; ignored characters that do not close an expression are
// dropped there and cost no back-end time. Classified commands pass through
// a short queue to the stack engine, which pushes a digit straight from its
// idle state, reads both operands of + - or * in a read state, and for / also
// waits for the bit-serial 32-bit divider, one quotient bit a cycle; a zero
// divisor skips the divider and sets the flag. The character marked last
// adds a final state that pops the result into the output register. The
// stack holds STACK_DEPTH values; its top is a register and the rest sits in
// a single-port-write memory, so no clearing pass is needed after reset.
`timescale 1ns / 1ps

module postfix_expression_evaluator_unit #(
    parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH_DEF,
    parameter int QUEUE_DEPTH = pfx_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pfx_pkg::pfx_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pfx_pkg::pfx_out_t m_data
);
    import pfx_pkg::*;

    logic         q_wvalid, q_wready, q_rvalid, q_rready;
    pfx_cmd_t     q_wdata, q_rdata;
    pfx_div_req_t div_req;
    pfx_div_rsp_t div_rsp;

    pfx_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_wvalid (q_wvalid),
        .q_wready (q_wready),
        .q_wdata  (q_wdata)
    );

    pfx_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wvalid  (q_wvalid),
        .wready  (q_wready),
        .wdata   (q_wdata),
        .rvalid  (q_rvalid),
        .rready  (q_rready),
        .rdata   (q_rdata)
    );

    pfx_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    pfx_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_rvalid (q_rvalid),
        .q_rready (q_rready),
        .q_rdata  (q_rdata),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ===== hw/rtl/pfx_front.sv =====
`timescale 1ns / 1ps

module pfx_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pfx_pkg::pfx_in_t  s_data,
    output logic              q_wvalid,
    input  logic              q_wready,
    output pfx_pkg::pfx_cmd_t q_wdata
);
    import pfx_pkg::*;

    logic     valid_reg, valid_next;
    pfx_cmd_t cmd_reg, cmd_next;
    pfx_cmd_t cls;
    logic     keep;
    logic [7:0] digit_off;

    // Classify the character into a command
    always_comb begin
        digit_off = s_data.ch - CHAR_ZERO;
        cls.digit = digit_off[3:0];
        cls.last  = s_data.last;
        priority if (s_data.ch >= CHAR_ZERO && s_data.ch <= CHAR_NINE) begin
            cls.kind = CMD_DIGIT;
        end else if (s_data.ch == CHAR_ADD) begin
            cls.kind = CMD_ADD;
        end else if (s_data.ch == CHAR_SUB) begin
            cls.kind = CMD_SUB;
        end else if (s_data.ch == CHAR_MUL) begin
            cls.kind = CMD_MUL;
        end else if (s_data.ch == CHAR_DIV) begin
            cls.kind = CMD_DIV;
        end else begin
            cls.kind = CMD_NONE;
        end
        // drop ignored characters unless they close the expression
        keep = (cls.kind != CMD_NONE) || s_data.last;
    end

    // Hold a classified command until the queue takes it
    always_comb begin
        s_ready    = !valid_reg || q_wready;
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (s_ready) begin
            valid_next = s_valid && keep;
            cmd_next   = cls;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        cmd_reg <= cmd_next;
    end

    assign q_wvalid = valid_reg;
    assign q_wdata  = cmd_reg;

endmodule

// ===== hw/rtl/pfx_queue.sv =====
`timescale 1ns / 1ps

module pfx_queue #(
    parameter int QUEUE_DEPTH = pfx_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wvalid,
    output logic              wready,
    input  pfx_pkg::pfx_cmd_t wdata,
    output logic              rvalid,
    input  logic              rready,
    output pfx_pkg::pfx_cmd_t rdata
);
    import pfx_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    pfx_cmd_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    // Advance pointers and occupancy
    always_comb begin
        wready    = (count_reg != FULL_CNT);
        rvalid    = (count_reg != '0);
        do_wr     = wvalid && wready;
        do_rd     = rvalid && rready;
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        if (do_wr) begin
            wptr_next = (wptr_reg == LAST_PTR) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (do_rd) begin
            rptr_next = (rptr_reg == LAST_PTR) ? '0 : rptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(do_wr) - CNT_W'(do_rd);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
        if (do_wr) begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

    assign rdata = slot_reg[rptr_reg];

endmodule

// ===== hw/rtl/pfx_div.sv =====
`timescale 1ns / 1ps

module pfx_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pfx_pkg::pfx_div_req_t req,
    output pfx_pkg::pfx_div_rsp_t rsp
);
    import pfx_pkg::*;

    localparam int STEP_W = $clog2(DATA_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              neg_reg, neg_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic              done_reg, done_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic [DATA_W:0]   rem_sh, rem_sub;
    logic              fits;
    logic [DATA_W-1:0] quo_sh;

    // Restoring division on magnitudes, one quotient bit per cycle
    always_comb begin
        rem_sh  = {rem_reg, quo_reg[DATA_W-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        fits    = (rem_sh >= {1'b0, dvs_reg});
        quo_sh  = {quo_reg[DATA_W-2:0], fits};

        busy_next = busy_reg;
        step_next = step_reg;
        neg_next  = neg_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        done_next = 1'b0;
        res_next  = res_reg;

        if (busy_reg) begin
            rem_next  = fits ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            quo_next  = quo_sh;
            step_next = step_reg + STEP_W'(1);
            if (step_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = neg_reg ? (DATA_W'(0) - quo_sh) : quo_sh;
            end
        end else if (req.start) begin
            busy_next = 1'b1;
            step_next = '0;
            neg_next  = req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
            dvs_next  = req.divisor[DATA_W-1] ? (DATA_W'(0) - req.divisor) : req.divisor;
            quo_next  = req.dividend[DATA_W-1] ? (DATA_W'(0) - req.dividend)
                                               : req.dividend;
            rem_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        step_reg <= step_next;
        neg_reg  <= neg_next;
        dvs_reg  <= dvs_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        res_reg  <= res_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = res_reg;

endmodule

// ===== hw/rtl/pfx_back.sv =====
`timescale 1ns / 1ps

module pfx_back #(
    parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_rvalid,
    output logic                  q_rready,
    input  pfx_pkg::pfx_cmd_t     q_rdata,
    output pfx_pkg::pfx_div_req_t div_req,
    input  pfx_pkg::pfx_div_rsp_t div_rsp,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pfx_pkg::pfx_out_t     m_data
);
    import pfx_pkg::*;

    // Top of stack lives in a register; the rest of the stack in memory
    localparam int MEM_DEPTH = STACK_DEPTH - 1;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO_CNT  = CNT_W'(2);

    pfx_back_state_t   state_reg, state_next;
    pfx_cmd_t          cmd_reg, cmd_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DATA_W-1:0] top_reg, top_next;
    logic              uf_reg, uf_next;
    logic              of_reg, of_next;
    logic              dz_reg, dz_next;
    logic              m_valid_reg, m_valid_next;
    pfx_out_t          m_data_reg, m_data_next;

    logic [DATA_W-1:0] mem [MEM_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;

    logic [CNT_W-1:0]  cnt_m1, cnt_m2;
    logic              cnt_zero, cnt_ge2;
    logic [DATA_W-1:0] op1, op2;
    logic              m_free;

    // Operand selection, with the empty value where a pop underflows
    always_comb begin
        cnt_m1    = count_reg - ONE_CNT;
        cnt_m2    = count_reg - TWO_CNT;
        cnt_zero  = (count_reg == '0);
        cnt_ge2   = (count_reg >= TWO_CNT);
        op2       = cnt_zero ? EMPTY_VALUE : top_reg;
        op1       = cnt_ge2 ? rd_data_reg : EMPTY_VALUE;
        mem_waddr = cnt_m1[ADDR_W-1:0];
        mem_raddr = cnt_ge2 ? cnt_m2[ADDR_W-1:0] : '0;
        m_free    = !m_valid_reg || m_ready;
    end

    // Sequence one command at a time
    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        count_next   = count_reg;
        top_next     = top_reg;
        uf_next      = uf_reg;
        of_next      = of_reg;
        dz_next      = dz_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        q_rready     = 1'b0;
        div_req      = '{start: 1'b0, dividend: op1, divisor: op2};

        unique case (state_reg)
            BK_IDLE: begin
                q_rready = 1'b1;
                if (q_rvalid) begin
                    cmd_next = q_rdata;
                    unique case (q_rdata.kind)
                        CMD_DIGIT: begin
                            // push, or drop and flag when full
                            if (count_reg == FULL_CNT) begin
                                of_next = 1'b1;
                            end else begin
                                mem_we     = !cnt_zero;
                                top_next   = DATA_W'(q_rdata.digit);
                                count_next = count_reg + ONE_CNT;
                            end
                            state_next = q_rdata.last ? BK_FIN : BK_IDLE;
                        end
                        CMD_NONE: begin
                            state_next = q_rdata.last ? BK_FIN : BK_IDLE;
                        end
                        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                            state_next = BK_READ;
                        end
                        default: begin
                            state_next = BK_IDLE;
                        end
                    endcase
                end
            end
            BK_READ: begin
                // pop two, push the result; the push always fits
                if (!cnt_ge2) begin
                    uf_next = 1'b1;
                end
                count_next = cnt_ge2 ? cnt_m1 : ONE_CNT;
                state_next = cmd_reg.last ? BK_FIN : BK_IDLE;
                unique case (cmd_reg.kind)
                    CMD_ADD: top_next = op1 + op2;
                    CMD_SUB: top_next = op1 - op2;
                    CMD_MUL: top_next = op1 * op2;
                    CMD_DIV: begin
                        if (op2 == '0) begin
                            top_next = '0;
                            dz_next  = 1'b1;
                        end else begin
                            div_req.start = 1'b1;
                            state_next    = BK_DIV;
                        end
                    end
                    default: top_next = top_reg;
                endcase
            end
            BK_DIV: begin
                if (div_rsp.done) begin
                    top_next   = div_rsp.quotient;
                    state_next = cmd_reg.last ? BK_FIN : BK_IDLE;
                end
            end
            BK_FIN: begin
                // emit the final pop with flags, then clear the expression
                if (m_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{value: cnt_zero ? EMPTY_VALUE : top_reg,
                                     underflow_seen: uf_reg || cnt_zero,
                                     overflow_seen: of_reg,
                                     div_zero_seen: dz_reg};
                    count_next   = '0;
                    uf_next      = 1'b0;
                    of_next      = 1'b0;
                    dz_next      = 1'b0;
                    state_next   = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            uf_reg      <= 1'b0;
            of_reg      <= 1'b0;
            dz_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            uf_reg      <= uf_next;
            of_reg      <= of_next;
            dz_reg      <= dz_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg    <= cmd_next;
        top_reg    <= top_next;
        m_data_reg <= m_data_next;
    end

    // Spill the old top below the new one; read the entry under the top
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= top_reg;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hw/rtl/pfx_checker.sv =====
`timescale 1ns / 1ps
`include "postfix_expression_evaluator_unit_defines.svh"

module pfx_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input pfx_pkg::pfx_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input pfx_pkg::pfx_out_t m_data
);
    import pfx_pkg::*;

    logic [3:0] pend_reg, pend_next;
    logic       in_last, out_xfer;

    // Track expressions closed at the input but not yet delivered
    always_comb begin
        in_last   = s_valid && s_ready && s_data.last;
        out_xfer  = m_valid && m_ready;
        pend_next = pend_reg + 4'(in_last) - 4'(out_xfer);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    `PFX_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_valid, "result valid after reset")
    `PFX_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "stalled result changed")
    `PFX_ASSERT(a_out_has_source, m_valid |-> pend_reg != 4'd0, "result without a closed expression")

endmodule

bind postfix_expression_evaluator_unit pfx_checker u_pfx_checker (.*);
